### hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

   // Fixed field widths.
   localparam int BASE_W     = 63;
   localparam int EXP_PORT_W = 63;
   localparam int EXP_WIDE_W = 64;
   localparam int MOD_W      = 32;
   localparam int CNT_W      = 6;

   // Configuration space: one 32-bit register, word addressed by paddr[2].
   localparam int ADDR_W     = 3;
   localparam int REG_IDX_W  = ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_MODULUS = '0;
   localparam logic [MOD_W-1:0]     MOD_RESET   = 32'd1000000007;

   // Loop counts, loaded as count minus one.
   localparam logic [CNT_W-1:0] RED_CNT = CNT_W'(BASE_W - 1);
   localparam logic [CNT_W-1:0] MUL_CNT = CNT_W'(MOD_W - 1);

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_RED_INIT,
      OP_RED_STEP,
      OP_BASE_LOAD,
      OP_MUL_INIT,
      OP_MOD_STEP,
      OP_ACC_LOAD,
      OP_SQ_INIT,
      OP_SQ_DONE,
      OP_OUT_LOAD
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_MOD_ZERO,
      COND_CNT_NZ,
      COND_EXP_ZERO,
      COND_EXP_EVEN,
      COND_OUT_BUSY
   } cond_type;

   typedef logic [3:0] step_type;

   localparam step_type STEP_ACCEPT    = 4'd0;
   localparam step_type STEP_RED_INIT  = 4'd1;
   localparam step_type STEP_RED_LOOP  = 4'd2;
   localparam step_type STEP_BASE_LOAD = 4'd3;
   localparam step_type STEP_BIT_TEST  = 4'd4;
   localparam step_type STEP_MUL_INIT  = 4'd5;
   localparam step_type STEP_MUL_LOOP  = 4'd6;
   localparam step_type STEP_ACC_LOAD  = 4'd7;
   localparam step_type STEP_SQ_INIT   = 4'd8;
   localparam step_type STEP_SQ_LOOP   = 4'd9;
   localparam step_type STEP_SQ_DONE   = 4'd10;
   localparam step_type STEP_FINISH    = 4'd11;
   localparam step_type STEP_LAST      = STEP_FINISH;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctl_word_type;

   typedef struct packed {
      logic mod_zero;
      logic cnt_nz;
      logic exp_zero;
      logic exp_lsb;
   } dp_status_type;

   // Microprogram: when the condition holds the sequencer jumps to target,
   // otherwise it falls through to the next step.
   function automatic ctl_word_type microcode(step_type step);
      ctl_word_type word;
      word = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_ACCEPT};
      unique case (step)
         STEP_ACCEPT:    word = '{op: OP_ACCEPT,    cond: COND_NO_REQ,   target: STEP_ACCEPT};
         STEP_RED_INIT:  word = '{op: OP_RED_INIT,  cond: COND_MOD_ZERO, target: STEP_FINISH};
         STEP_RED_LOOP:  word = '{op: OP_RED_STEP,  cond: COND_CNT_NZ,   target: STEP_RED_LOOP};
         STEP_BASE_LOAD: word = '{op: OP_BASE_LOAD, cond: COND_NEVER,    target: STEP_ACCEPT};
         STEP_BIT_TEST:  word = '{op: OP_NOP,       cond: COND_EXP_ZERO, target: STEP_FINISH};
         STEP_MUL_INIT:  word = '{op: OP_MUL_INIT,  cond: COND_EXP_EVEN, target: STEP_SQ_INIT};
         STEP_MUL_LOOP:  word = '{op: OP_MOD_STEP,  cond: COND_CNT_NZ,   target: STEP_MUL_LOOP};
         STEP_ACC_LOAD:  word = '{op: OP_ACC_LOAD,  cond: COND_NEVER,    target: STEP_ACCEPT};
         STEP_SQ_INIT:   word = '{op: OP_SQ_INIT,   cond: COND_NEVER,    target: STEP_ACCEPT};
         STEP_SQ_LOOP:   word = '{op: OP_MOD_STEP,  cond: COND_CNT_NZ,   target: STEP_SQ_LOOP};
         STEP_SQ_DONE:   word = '{op: OP_SQ_DONE,   cond: COND_ALWAYS,   target: STEP_BIT_TEST};
         STEP_FINISH:    word = '{op: OP_OUT_LOAD,  cond: COND_OUT_BUSY, target: STEP_FINISH};
         default:        word = '{op: OP_NOP,       cond: COND_ALWAYS,   target: STEP_ACCEPT};
      endcase
      return word;
   endfunction

endpackage

### hw/rtl/mexp_sequencer.sv
`timescale 1ns / 1ps

module mexp_sequencer
   import mexp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          out_busy,
   input  dp_status_type status,
   output ctl_word_type  ctl,
   output step_type      step
);

   step_type step_ff;
   step_type step_in;
   logic     taken;

   assign ctl  = microcode(step_ff);
   assign step = step_ff;

   always_comb begin
      unique case (ctl.cond)
         COND_NEVER:    taken = 1'b0;
         COND_ALWAYS:   taken = 1'b1;
         COND_NO_REQ:   taken = !req_valid;
         COND_MOD_ZERO: taken = status.mod_zero;
         COND_CNT_NZ:   taken = status.cnt_nz;
         COND_EXP_ZERO: taken = status.exp_zero;
         COND_EXP_EVEN: taken = !status.exp_lsb;
         COND_OUT_BUSY: taken = out_busy;
         default:       taken = 1'b1;
      endcase
   end

   always_comb begin
      if (taken) begin
         step_in = ctl.target;
      end else if (step_ff == STEP_LAST) begin
         step_in = STEP_ACCEPT;
      end else begin
         step_in = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_ACCEPT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### hw/rtl/mexp_datapath.sv
`timescale 1ns / 1ps

module mexp_datapath
   import mexp_pkg::*;
#(
   parameter int EXP_BITS = 63
) (
   input  logic                  clock,
   input  op_type                op,
   input  logic                  req_valid,
   input  logic [BASE_W-1:0]     req_base_value,
   input  logic [EXP_PORT_W-1:0] req_exponent,
   input  logic [MOD_W-1:0]      modulus,
   output logic [MOD_W-1:0]      acc,
   output dp_status_type         status
);

   logic [BASE_W-1:0]     base_ff;
   logic [EXP_BITS-1:0]   exp_ff;
   logic [MOD_W-1:0]      acc_ff;
   logic [MOD_W-1:0]      b_ff;
   logic [MOD_W-1:0]      y_ff;
   logic [MOD_W-1:0]      r_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic [EXP_WIDE_W-1:0] exp_wide;
   logic [EXP_BITS-1:0]   exp_load;
   logic [MOD_W-1:0]      addend;
   logic [MOD_W+1:0]      sum;
   logic [MOD_W+1:0]      one_m;
   logic [MOD_W+1:0]      two_m;
   logic [MOD_W+1:0]      reduced;
   logic [MOD_W-1:0]      r_in;

   assign exp_wide = {{(EXP_WIDE_W - EXP_PORT_W){1'b0}}, req_exponent};
   assign exp_load = exp_wide[EXP_BITS-1:0];

   // One shift-add-reduce step: r = (2r + addend) mod m, with r and the
   // addend both below m so that the sum stays below 3m.
   always_comb begin
      if (op == OP_RED_STEP) begin
         addend = {{(MOD_W - 1){1'b0}}, base_ff[BASE_W-1]};
      end else if (y_ff[MOD_W-1]) begin
         addend = b_ff;
      end else begin
         addend = '0;
      end
      sum   = {1'b0, r_ff, 1'b0} + {2'b00, addend};
      one_m = {2'b00, modulus};
      two_m = {1'b0, modulus, 1'b0};
      if (sum >= two_m) begin
         reduced = sum - two_m;
      end else if (sum >= one_m) begin
         reduced = sum - one_m;
      end else begin
         reduced = sum;
      end
      r_in = reduced[MOD_W-1:0];
   end

   always_ff @(posedge clock) begin
      unique case (op)
         OP_ACCEPT: begin
            if (req_valid) begin
               base_ff <= req_base_value;
               exp_ff  <= exp_load;
               acc_ff  <= (modulus == '0) ? '0 : {{(MOD_W - 1){1'b0}}, 1'b1};
            end
         end
         OP_RED_INIT: begin
            r_ff   <= '0;
            cnt_ff <= RED_CNT;
         end
         OP_RED_STEP: begin
            r_ff    <= r_in;
            base_ff <= {base_ff[BASE_W-2:0], 1'b0};
            cnt_ff  <= cnt_ff - CNT_W'(1);
         end
         OP_BASE_LOAD: begin
            b_ff <= r_ff;
         end
         OP_MUL_INIT: begin
            r_ff   <= '0;
            y_ff   <= acc_ff;
            cnt_ff <= MUL_CNT;
         end
         OP_MOD_STEP: begin
            r_ff   <= r_in;
            y_ff   <= {y_ff[MOD_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         OP_ACC_LOAD: begin
            acc_ff <= r_ff;
         end
         OP_SQ_INIT: begin
            r_ff   <= '0;
            y_ff   <= b_ff;
            cnt_ff <= MUL_CNT;
         end
         OP_SQ_DONE: begin
            b_ff   <= r_ff;
            exp_ff <= exp_ff >> 1;
         end
         default: begin
         end
      endcase
   end

   assign acc             = acc_ff;
   assign status.mod_zero = (modulus == '0);
   assign status.cnt_nz   = (cnt_ff != '0);
   assign status.exp_zero = (exp_ff == '0);
   assign status.exp_lsb  = exp_ff[0];

endmodule

### hw/rtl/modular_exponentiation.sv
`timescale 1ns / 1ps

// Modular exponentiation: each transfer on the req_ channel carries a base
// and an exponent, and one transfer on the rsp_ channel returns
// base^exponent mod modulus, computed by right-to-left square-and-multiply.
// The modulus is a 32-bit register at byte address 0 of the csr_ port; it
// resets to 1000000007 and should only be written while no item is in
// flight. An exponent of zero returns 1 even for a modulus of one, and a
// modulus of zero returns 0 for every item. Only the low EXP_BITS bits of
// the exponent are used. One item is worked on at a time. A small
// microprogram steps a shared shift-add-reduce unit that retires one bit
// per cycle, so the rate is set by that unit, which reduces the base and
// forms every modular product one bit at a time. Each exponent bit up to
// the highest set one costs a squaring and each set bit a multiplication;
// a zero exponent skips both. A modulus of zero goes straight from the
// reduction setup to the finish step. A finished result sits in an output
// register, and the next item is taken as soon as that register is loaded.

module modular_exponentiation
   import mexp_pkg::*;
#(
   parameter int EXP_BITS = 63
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BASE_W-1:0]     req_base_value,
   input  logic [EXP_PORT_W-1:0] req_exponent,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MOD_W-1:0]      rsp_power_result,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_W-1:0]     csr_paddr,
   input  logic [MOD_W-1:0]      csr_pwdata,
   output logic [MOD_W-1:0]      csr_prdata,
   output logic                  csr_pready
);

   logic [MOD_W-1:0]     modulus_ff;
   logic                 rsp_valid_ff;
   logic [MOD_W-1:0]     rsp_power_result_ff;

   ctl_word_type         ctl;
   step_type             step;
   dp_status_type        status;
   logic [MOD_W-1:0]     acc;
   logic                 out_busy;
   logic                 out_load;
   logic [REG_IDX_W-1:0] reg_index;
   logic                 csr_write;

   // Register access. The word index is the byte address over four; the
   // port never inserts wait states.
   assign reg_index  = csr_paddr[ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (reg_index == REG_MODULUS) ? modulus_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_RESET;
      end else if (csr_write && (reg_index == REG_MODULUS)) begin
         modulus_ff <= csr_pwdata;
      end
   end

   // The sequencer fetches one control word per step from its microprogram
   // and branches on the datapath status, the request valid and the state
   // of the output register.
   mexp_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_busy  (out_busy),
      .status    (status),
      .ctl       (ctl),
      .step      (step)
   );

   // The datapath holds the operands, the running result and the loop
   // counter, and the one reduction unit that the reduction and product loops share.
   mexp_datapath #(
      .EXP_BITS (EXP_BITS)
   ) u_datapath (
      .clock          (clock),
      .op             (ctl.op),
      .req_valid      (req_valid),
      .req_base_value (req_base_value),
      .req_exponent   (req_exponent),
      .modulus        (modulus_ff),
      .acc            (acc),
      .status         (status)
   );

   // A request transfer happens only in the accept step of the program.
   assign req_stall = (ctl.op != OP_ACCEPT);

   // The output register takes a new result only once the previous one has
   // been transferred; until then the finish step waits.
   assign out_busy = rsp_valid_ff && rsp_stall;
   assign out_load = (ctl.op == OP_OUT_LOAD) && !out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_power_result_ff <= acc;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_power_result_ff;

`ifndef SYNTHESIS
   // After a request transfer the program leaves the accept step, so a
   // second item cannot be taken before the first one is finished.
   a_one_item_in_flight : assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall
   ) else $error("request accepted while an item is in flight");

   // The step counter never runs past the end of the microprogram.
   a_step_in_program : assert property (
      @(posedge clock) disable iff (reset)
      step <= STEP_LAST
   ) else $error("sequencer step outside the microprogram");

   // A result only appears after the finish step loaded it.
   a_result_from_finish : assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(step == STEP_FINISH)
   ) else $error("result valid raised outside the finish step");
`endif

endmodule
